// ----- rtl/sto_pkg.sv -----
package sto_pkg;

    // geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int WORD_W      = 32;
    localparam int DRAW_W      = 10;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PARK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PARK = 1'd1;
    localparam logic [WORD_W-1:0] MIN_PARK_RESET = 32'd100;
    localparam logic [WORD_W-1:0] MAX_PARK_RESET = 32'd1000;

    // duration scaling: draw is in thousandths
    localparam logic [DRAW_W-1:0] DRAW_FULL = 10'd1000;
    localparam int PROD_W = 43;          // signed (33 bit diff) * (11 bit draw)
    localparam int MAG_W  = PROD_W - 1;  // magnitude of the product
    localparam int REM_W  = 10;          // remainder below 1000
    localparam int DIV_STEPS  = 6;       // quotient bits per cycle
    localparam int DIV_CYCLES = MAG_W / DIV_STEPS;

    // per cell contents
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] tag;
        logic [WORD_W-1:0] remaining;
        logic [WORD_W-1:0] duration;
    } cell_t;

    // command broadcast to every cell
    typedef enum logic [1:0] {
        OP_NOP,
        OP_LOWER,
        OP_INSERT,
        OP_POP
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] tag;
    } cell_cmd_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ABS,
        ST_DIV,
        ST_ADD,
        ST_INS,
        ST_POP,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/sto_in_if.sv -----
interface sto_in_if;
    logic                            valid;
    logic                            ready;
    logic                            mode;
    logic [sto_pkg::WORD_W-1:0]      tag;
    logic [sto_pkg::DRAW_W-1:0]      draw;
    logic [sto_pkg::WORD_W-1:0]      elapsed;

    modport source (output valid, mode, tag, draw, elapsed, input ready);
    modport sink   (input valid, mode, tag, draw, elapsed, output ready);
endinterface

// ----- rtl/sto_out_if.sv -----
interface sto_out_if;
    logic                            valid;
    logic                            ready;
    logic                            departed;
    logic [sto_pkg::WORD_W-1:0]      out_tag;
    logic [sto_pkg::WORD_W-1:0]      out_duration;
    logic [sto_pkg::WORD_W-1:0]      next_wait;
    logic                            overflow;

    modport source (output valid, departed, out_tag, out_duration, next_wait, overflow,
                    input ready);
    modport sink   (input valid, departed, out_tag, out_duration, next_wait, overflow,
                    output ready);
endinterface

// ----- rtl/sorted_timeout_queue_core.sv -----
// Timer queue of QUEUE_DEPTH tagged entries kept in a chain of cells ordered by
// remaining time. Each input request is an arrival (mode 0: all remaining times
// drop by elapsed, saturating, then the entry is placed ahead of equal times with
// duration min + (max - min) * draw / 1000, truncated toward zero, or dropped
// with overflow when full) or an expiry (mode 1: the front entry leaves, and the
// rest drop by its remaining time). Every request gives exactly one result with
// next_wait, all ones when empty. An arrival waits on the divide by 1000, which a
// divider unit does six quotient bits per cycle; an expiry or an arrival to a
// full queue skips the divide. A new request is taken while the previous result
// still waits in the output register. The user must write configuration only while
// no request is in flight; the block itself does not enforce this.
module sorted_timeout_queue_core #(
    parameter int QUEUE_DEPTH = sto_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sto_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sto_pkg::WORD_W-1:0]      cfg_data,
    sto_in_if.sink                          in_ch,
    sto_out_if.source                       out_ch
);

    localparam int W = sto_pkg::WORD_W;

    sto_pkg::state_t state_reg;
    sto_pkg::state_t state_next;

    logic [W-1:0] min_reg;
    logic [W-1:0] max_reg;

    // latched request
    logic                        mode_reg;
    logic [W-1:0]                tag_reg;
    logic [sto_pkg::DRAW_W-1:0]  draw_reg;
    logic [W-1:0]                elapsed_reg;

    // duration datapath
    logic signed [W:0]                 diff;
    logic signed [sto_pkg::DRAW_W:0]   draw_s;
    logic signed [sto_pkg::PROD_W-1:0] prod_next;
    logic signed [sto_pkg::PROD_W-1:0] prod_reg;
    logic [sto_pkg::PROD_W-1:0]        prod_neg;
    logic [sto_pkg::MAG_W-1:0]         mag;
    logic                              neg_reg;
    logic [W-1:0]                      dur_reg;
    logic [sto_pkg::MAG_W-1:0]         quotient;
    logic                              div_done;
    logic [W-1:0]                      q_low;

    // result being built
    logic         departed_reg;
    logic [W-1:0] otag_reg;
    logic [W-1:0] odur_reg;
    logic         ovf_reg;

    // output register
    logic         out_valid_reg;
    logic         out_departed_reg;
    logic [W-1:0] out_tag_reg;
    logic [W-1:0] out_dur_reg;
    logic [W-1:0] out_wait_reg;
    logic         out_ovf_reg;

    logic in_fire;
    logic out_load;
    logic full;

    sto_pkg::cell_cmd_t cmd;
    sto_pkg::cell_t     cells [QUEUE_DEPTH];
    logic               lt    [QUEUE_DEPTH];

    assign in_ch.ready = (state_reg == sto_pkg::ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_load    = (state_reg == sto_pkg::ST_DONE) && (!out_valid_reg || out_ch.ready);
    assign full        = cells[QUEUE_DEPTH-1].valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= sto_pkg::MIN_PARK_RESET;
            max_reg <= sto_pkg::MAX_PARK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sto_pkg::CFG_MIN_PARK: min_reg <= cfg_data;
                sto_pkg::CFG_MAX_PARK: max_reg <= cfg_data;
                default:               min_reg <= min_reg;
            endcase
        end
    end

    // signed range times draw
    assign diff      = $signed({1'b0, max_reg}) - $signed({1'b0, min_reg});
    assign draw_s    = $signed({1'b0, draw_reg});
    assign prod_next = diff * draw_s;
    assign prod_neg  = sto_pkg::PROD_W'(-prod_reg);
    assign mag       = prod_reg[sto_pkg::PROD_W-1] ? prod_neg[sto_pkg::MAG_W-1:0]
                                                   : prod_reg[sto_pkg::MAG_W-1:0];
    assign q_low     = quotient[W-1:0];

    sto_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == sto_pkg::ST_ABS),
        .dividend (mag),
        .done     (div_done),
        .quotient (quotient)
    );

    // cell command for the current state
    always_comb
    begin
        cmd.op    = sto_pkg::OP_NOP;
        cmd.value = dur_reg;
        cmd.tag   = tag_reg;
        unique case (state_reg)
            sto_pkg::ST_MUL:
            begin
                cmd.op    = sto_pkg::OP_LOWER;
                cmd.value = elapsed_reg;
            end
            sto_pkg::ST_INS:
            begin
                cmd.op = sto_pkg::OP_INSERT;
            end
            sto_pkg::ST_POP:
            begin
                cmd.op    = cells[0].valid ? sto_pkg::OP_POP : sto_pkg::OP_NOP;
                cmd.value = cells[0].remaining;
            end
            default:
            begin
                cmd.op = sto_pkg::OP_NOP;
            end
        endcase
    end

    // chain of cells
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        sto_pkg::cell_t prev_c;
        sto_pkg::cell_t next_c;
        logic           prev_l;
        if (i == 0)
        begin : g_first
            assign prev_c = '0;
            assign prev_l = 1'b1;
        end
        else
        begin : g_mid
            assign prev_c = cells[i-1];
            assign prev_l = lt[i-1];
        end
        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign next_c = '0;
        end
        else
        begin : g_inner
            assign next_c = cells[i+1];
        end
        sto_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .prev    (prev_c),
            .prev_lt (prev_l),
            .next    (next_c),
            .cur     (cells[i]),
            .lt      (lt[i])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sto_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = in_ch.mode ? sto_pkg::ST_POP : sto_pkg::ST_MUL;
                end
            end
            sto_pkg::ST_MUL:  state_next = full ? sto_pkg::ST_DONE : sto_pkg::ST_ABS;
            sto_pkg::ST_ABS:  state_next = sto_pkg::ST_DIV;
            sto_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = sto_pkg::ST_ADD;
                end
            end
            sto_pkg::ST_ADD:  state_next = sto_pkg::ST_INS;
            sto_pkg::ST_INS:  state_next = sto_pkg::ST_DONE;
            sto_pkg::ST_POP:  state_next = sto_pkg::ST_DONE;
            sto_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = sto_pkg::ST_IDLE;
                end
            end
            default:          state_next = sto_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sto_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // request capture and duration datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg     <= in_ch.mode;
            tag_reg      <= in_ch.tag;
            draw_reg     <= (in_ch.draw > sto_pkg::DRAW_FULL) ? sto_pkg::DRAW_FULL : in_ch.draw;
            elapsed_reg  <= in_ch.elapsed;
            departed_reg <= 1'b0;
            otag_reg     <= '0;
            odur_reg     <= '0;
            ovf_reg      <= 1'b0;
        end
        if (state_reg == sto_pkg::ST_MUL)
        begin
            prod_reg <= prod_next;
            ovf_reg  <= full && !mode_reg;
        end
        if (state_reg == sto_pkg::ST_ABS)
        begin
            neg_reg <= prod_reg[sto_pkg::PROD_W-1];
        end
        if (state_reg == sto_pkg::ST_ADD)
        begin
            dur_reg <= neg_reg ? min_reg - q_low : min_reg + q_low;
        end
        if ((state_reg == sto_pkg::ST_POP) && cells[0].valid)
        begin
            departed_reg <= 1'b1;
            otag_reg     <= cells[0].tag;
            odur_reg     <= cells[0].duration;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_departed_reg <= departed_reg;
            out_tag_reg      <= otag_reg;
            out_dur_reg      <= odur_reg;
            out_wait_reg     <= cells[0].valid ? cells[0].remaining : '1;
            out_ovf_reg      <= ovf_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.departed     = out_departed_reg;
    assign out_ch.out_tag      = out_tag_reg;
    assign out_ch.out_duration = out_dur_reg;
    assign out_ch.next_wait    = out_wait_reg;
    assign out_ch.overflow     = out_ovf_reg;

endmodule

// ----- rtl/sto_cell.sv -----
module sto_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  sto_pkg::cell_cmd_t  cmd,
    input  sto_pkg::cell_t      prev,
    input  logic                prev_lt,
    input  sto_pkg::cell_t      next,
    output sto_pkg::cell_t      cur,
    output logic                lt
);

    sto_pkg::cell_t cell_reg;
    sto_pkg::cell_t cell_next;
    logic [sto_pkg::WORD_W-1:0] lowered;
    logic [sto_pkg::WORD_W-1:0] next_lowered;

    assign cur = cell_reg;

    // this entry stays ahead of a new arrival with the broadcast duration
    assign lt = cell_reg.valid && (cell_reg.remaining < cmd.value);

    // saturating subtract for own and neighbor's remaining time
    assign lowered      = (cell_reg.remaining > cmd.value) ?
                          cell_reg.remaining - cmd.value : '0;
    assign next_lowered = (next.remaining > cmd.value) ?
                          next.remaining - cmd.value : '0;

    // next cell contents
    always_comb
    begin
        cell_next = cell_reg;
        unique case (cmd.op)
            sto_pkg::OP_NOP:
            begin
                cell_next = cell_reg;
            end
            sto_pkg::OP_LOWER:
            begin
                cell_next.remaining = lowered;
            end
            sto_pkg::OP_INSERT:
            begin
                if (lt)
                begin
                    cell_next = cell_reg;
                end
                else if (prev_lt)
                begin
                    cell_next.valid     = 1'b1;
                    cell_next.tag       = cmd.tag;
                    cell_next.remaining = cmd.value;
                    cell_next.duration  = cmd.value;
                end
                else
                begin
                    cell_next = prev;
                end
            end
            sto_pkg::OP_POP:
            begin
                cell_next           = next;
                cell_next.remaining = next_lowered;
            end
            default:
            begin
                cell_next = cell_reg;
            end
        endcase
    end

    // cell register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

endmodule

// ----- rtl/sto_divider.sv -----
module sto_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sto_pkg::MAG_W-1:0]   dividend,
    output logic                        done,
    output logic [sto_pkg::MAG_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(sto_pkg::DIV_CYCLES);
    localparam logic [sto_pkg::REM_W:0] DIVISOR = (sto_pkg::REM_W + 1)'(sto_pkg::DRAW_FULL);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(sto_pkg::DIV_CYCLES - 1);

    logic [sto_pkg::MAG_W-1:0] num_reg;
    logic [sto_pkg::MAG_W-1:0] num_next;
    logic [sto_pkg::REM_W-1:0] rem_reg;
    logic [sto_pkg::REM_W-1:0] rem_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    assign done     = done_reg;
    assign quotient = num_reg;

    // several restoring steps by the constant divisor per cycle
    always_comb
    begin
        logic [sto_pkg::REM_W:0] trial;
        num_next = num_reg;
        rem_next = rem_reg;
        for (int k = 0; k < sto_pkg::DIV_STEPS; k++)
        begin
            trial    = {rem_next, num_next[sto_pkg::MAG_W-1]};
            num_next = {num_next[sto_pkg::MAG_W-2:0], 1'b0};
            if (trial >= DIVISOR)
            begin
                rem_next    = sto_pkg::REM_W'(trial - DIVISOR);
                num_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[sto_pkg::REM_W-1:0];
            end
        end
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out as quotient shifts in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

endmodule

// ----- test/tb_top.sv -----
module tb_top;

    localparam int WORD_W      = sto_pkg::WORD_W;
    localparam int DRAW_W      = sto_pkg::DRAW_W;
    localparam int QUEUE_DEPTH = sto_pkg::QUEUE_DEPTH;

    // request kinds on the input channel
    localparam logic MODE_ARRIVAL = 1'b0;
    localparam logic MODE_EXPIRY  = 1'b1;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_COUNT   = 9;

    typedef struct packed {
        logic              departed;
        logic [WORD_W-1:0] out_tag;
        logic [WORD_W-1:0] out_duration;
        logic [WORD_W-1:0] next_wait;
        logic              overflow;
    } timer_report_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [sto_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]             cfg_data;

    sto_in_if  in_ch ();
    sto_out_if out_ch ();

    sorted_timeout_queue_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // shadow copy of the timer queue and its park time registers
    logic [WORD_W-1:0] shadow_tag       [QUEUE_DEPTH];
    logic [WORD_W-1:0] shadow_remaining [QUEUE_DEPTH];
    logic [WORD_W-1:0] shadow_duration  [QUEUE_DEPTH];
    int                shadow_count;
    logic [WORD_W-1:0] park_min;
    logic [WORD_W-1:0] park_max;

    timer_report_t     pending_reports [$];
    int                mismatch_count = 0;
    bit                idle_off = 1'b0;
    logic [WORD_W-1:0] tick_span = 32'd400;
    int                out_hold = 0;
    int                quiet_cycles = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // duration drawn between the park times, truncated toward zero
    function automatic logic [WORD_W-1:0] park_duration(logic [DRAW_W-1:0] draw);
        longint span;
        longint scaled;
        longint fraction;
        longint total;
        span = $signed({32'd0, park_max}) - $signed({32'd0, park_min});
        scaled = (draw > sto_pkg::DRAW_FULL) ? longint'(sto_pkg::DRAW_FULL) : longint'(draw);
        fraction = span * scaled / longint'(sto_pkg::DRAW_FULL);
        total = $signed({32'd0, park_min}) + fraction;
        return total[WORD_W-1:0];
    endfunction

    // saturating subtract on every stored entry
    function automatic void lower_entries(logic [WORD_W-1:0] by);
        for (int i = 0; i < shadow_count; i++)
        begin
            shadow_remaining[i] = (shadow_remaining[i] > by) ? shadow_remaining[i] - by : '0;
        end
    endfunction

    // apply one request to the shadow queue and return the report it yields
    function automatic timer_report_t advance_timer_queue(logic mode, logic [WORD_W-1:0] tag,
                                                          logic [DRAW_W-1:0] draw,
                                                          logic [WORD_W-1:0] elapsed);
        timer_report_t     rpt;
        logic [WORD_W-1:0] dur;
        logic [WORD_W-1:0] popped;
        int                pos;
        rpt = '0;
        if (mode == MODE_ARRIVAL)
        begin
            lower_entries(elapsed);
            if (shadow_count >= QUEUE_DEPTH)
            begin
                rpt.overflow = 1'b1;
            end
            else
            begin
                dur = park_duration(draw);
                pos = 0;
                while (pos < shadow_count && shadow_remaining[pos] < dur)
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                begin
                    shadow_tag[i]       = shadow_tag[i-1];
                    shadow_remaining[i] = shadow_remaining[i-1];
                    shadow_duration[i]  = shadow_duration[i-1];
                end
                shadow_tag[pos]       = tag;
                shadow_remaining[pos] = dur;
                shadow_duration[pos]  = dur;
                shadow_count++;
            end
        end
        else if (shadow_count > 0)
        begin
            rpt.departed     = 1'b1;
            rpt.out_tag      = shadow_tag[0];
            rpt.out_duration = shadow_duration[0];
            popped = shadow_remaining[0];
            for (int i = 1; i < shadow_count; i++)
            begin
                shadow_tag[i-1]       = shadow_tag[i];
                shadow_remaining[i-1] = shadow_remaining[i];
                shadow_duration[i-1]  = shadow_duration[i];
            end
            shadow_count--;
            lower_entries(popped);
        end
        rpt.next_wait = (shadow_count == 0) ? '1 : shadow_remaining[0];
        return rpt;
    endfunction

    function automatic void compare_field(string field, logic [WORD_W-1:0] want,
                                          logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_report();
        timer_report_t want;
        if (pending_reports.size() == 0)
        begin
            $display("%0t: result with no request pending, expected none actual next_wait %h",
                     $time, out_ch.next_wait);
            mismatch_count++;
        end
        else
        begin
            want = pending_reports[0];
            pending_reports.delete(0);
            compare_field("departed", WORD_W'(want.departed), WORD_W'(out_ch.departed));
            compare_field("out_tag", want.out_tag, out_ch.out_tag);
            compare_field("out_duration", want.out_duration, out_ch.out_duration);
            compare_field("next_wait", want.next_wait, out_ch.next_wait);
            compare_field("overflow", WORD_W'(want.overflow), WORD_W'(out_ch.overflow));
        end
    endfunction

    function automatic int draw_hold();
        return idle_off ? 0 : $urandom_range(0, 9);
    endfunction

    // result side: check each accepted result, then stall ready at random
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            check_report();
            out_hold = draw_hold();
        end
        if (out_hold > 0)
        begin
            out_hold--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // one request: random gap, then hold valid until taken
    task automatic send_request(logic mode, logic [WORD_W-1:0] tag, logic [DRAW_W-1:0] draw,
                                logic [WORD_W-1:0] elapsed);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= mode;
        in_ch.tag     <= tag;
        in_ch.draw    <= draw;
        in_ch.elapsed <= elapsed;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        pending_reports.push_back(advance_timer_queue(mode, tag, draw, elapsed));
    endtask

    // stop sending and wait for every result to come back
    task automatic settle_queue();
        in_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_park_times(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
        settle_queue();
        cfg_we    <= 1'b1;
        cfg_index <= sto_pkg::CFG_MIN_PARK;
        cfg_data  <= lo;
        @(posedge clk);
        park_min = lo;
        cfg_index <= sto_pkg::CFG_MAX_PARK;
        cfg_data  <= hi;
        @(posedge clk);
        park_max = hi;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [DRAW_W-1:0] pick_draw();
        case ($urandom_range(0, 9))
            0:       return 10'd0;
            1:       return sto_pkg::DRAW_FULL;
            2:       return DRAW_W'($urandom_range(1001, 1023));
            default: return DRAW_W'($urandom_range(0, 1000));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_elapsed();
        case ($urandom_range(0, 7))
            0, 1:    return '0;
            2:       return $urandom;
            3:       return '1;
            default: return $urandom_range(0, tick_span);
        endcase
    endfunction

    // mixed arrivals and expiries; expiries carry noise in the unused fields
    task automatic run_mix(int count, int arrive_pct);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < arrive_pct)
                send_request(MODE_ARRIVAL, $urandom, pick_draw(), pick_elapsed());
            else
                send_request(MODE_EXPIRY, $urandom, DRAW_W'($urandom_range(0, 1023)),
                             $urandom);
        end
    endtask

    // field extremes, clamped draw, ties, saturation, expiry on empty
    task automatic test_directed();
        send_request(MODE_EXPIRY, 32'h1234_5678, 10'd0, 32'd0);
        send_request(MODE_ARRIVAL, 32'h0000_0000, 10'd0, 32'd0);
        send_request(MODE_ARRIVAL, 32'hFFFF_FFFF, 10'd1000, 32'd0);
        send_request(MODE_ARRIVAL, 32'hA5A5_0001, 10'd1023, 32'd0);
        send_request(MODE_ARRIVAL, 32'h5A5A_0002, 10'd500, 32'd50);
        send_request(MODE_ARRIVAL, 32'h0000_0003, 10'd1, 32'd0);
        send_request(MODE_ARRIVAL, 32'h0000_0004, 10'd999, 32'd7);
        send_request(MODE_ARRIVAL, 32'h0000_0005, 10'h155, 32'd0);
        send_request(MODE_ARRIVAL, 32'h0000_0006, 10'h2AA, 32'hFFFF_FFFF);
        send_request(MODE_ARRIVAL, 32'h8000_0007, 10'd512, 32'h8000_0000);
        repeat (11) send_request(MODE_EXPIRY, 32'hFFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF);
    endtask

    // fill to depth, arrivals while full, then drain past empty
    task automatic test_overflow();
        repeat (QUEUE_DEPTH)
            send_request(MODE_ARRIVAL, $urandom, DRAW_W'($urandom_range(0, 1000)),
                         $urandom_range(0, 50));
        send_request(MODE_ARRIVAL, 32'hDEAD_0001, 10'd0, 32'd30);
        send_request(MODE_ARRIVAL, 32'hDEAD_0002, 10'd1000, 32'hFFFF_FFFF);
        send_request(MODE_EXPIRY, 32'd0, 10'd0, 32'd0);
        send_request(MODE_ARRIVAL, 32'hDEAD_0003, 10'd300, 32'd0);
        repeat (QUEUE_DEPTH + 1) send_request(MODE_EXPIRY, 32'd0, 10'd0, 32'd0);
    endtask

    // zero, all-ones and reversed park times
    task automatic test_park_extremes();
        logic [WORD_W-1:0] lo_set   [4];
        logic [WORD_W-1:0] hi_set   [4];
        logic [DRAW_W-1:0] draw_set [6];
        lo_set   = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFE};
        hi_set   = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE};
        draw_set = '{10'd0, 10'd1, 10'd500, 10'd999, 10'd1000, 10'd1023};
        for (int s = 0; s < 4; s++)
        begin
            write_park_times(lo_set[s], hi_set[s]);
            foreach (draw_set[d])
                send_request(MODE_ARRIVAL, $urandom, draw_set[d], 32'd0);
            send_request(MODE_ARRIVAL, $urandom, 10'd250, 32'd1);
            repeat (7) send_request(MODE_EXPIRY, $urandom, 10'd0, 32'd0);
        end
    endtask

    // random phases, each under its own park time setting
    task automatic test_random_phases();
        logic [WORD_W-1:0] lo_set  [PHASE_COUNT];
        logic [WORD_W-1:0] hi_set  [PHASE_COUNT];
        int                pct_set [PHASE_COUNT];
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        lo_set  = '{32'd100, 32'd0, 32'd0, 32'd5000, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd10,
                    32'd100};
        hi_set  = '{32'd1000, 32'd0, 32'd0, 32'd20, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
                    32'd12, 32'd1000};
        pct_set = '{50, 40, 60, 55, 50, 45, 60, 70, 35};
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            lo = lo_set[phase];
            hi = hi_set[phase];
            if (phase == 2)
            begin
                lo = $urandom_range(0, 500);
                hi = lo + $urandom_range(0, 3000);
            end
            else if (phase == 6)
            begin
                lo = $urandom;
                hi = $urandom;
            end
            write_park_times(lo, hi);
            tick_span = ((lo > hi) ? lo : hi) >> 2;
            if (tick_span == 0)
                tick_span = 1;
            idle_off = (phase == 2 || phase == 6);
            run_mix(88, pct_set[phase]);
        end
        idle_off = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.mode    = MODE_ARRIVAL;
        in_ch.tag     = '0;
        in_ch.draw    = '0;
        in_ch.elapsed = '0;
        out_ch.ready  = 1'b0;
        park_min      = sto_pkg::MIN_PARK_RESET;
        park_max      = sto_pkg::MAX_PARK_RESET;
        shadow_count  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_overflow();
        test_park_extremes();
        test_random_phases();

        settle_queue();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
